// ===== sv/yuvrgb_pkg.sv =====
// ----------------------------------------------------------------------------
// yuvrgb_pkg
// Shared codes, gain constants and pipeline control types for the Y'UV to
// R'G'B' / Y'CbCr pixel converter.
// ----------------------------------------------------------------------------
package yuvrgb_pkg;

  localparam int GAIN_FRAC_BITS_DEF = 24;

  // width of the Q16 matrix constants
  localparam int KQ_W   = 34;
  localparam int KQ_NUM = 8;

  typedef enum logic [1:0] {
    FMT_RGB48  = 2'd0,
    FMT_YCC444 = 2'd1,
    FMT_GRAY16 = 2'd2
  } out_fmt_t;

  typedef enum logic [1:0] {
    CFG_OUTPUT_FORMAT = 2'd0,
    CFG_BLACK_LEVEL   = 2'd1,
    CFG_WHITE_LEVEL   = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    G_RGB_Y = 3'd0,
    G_R_V   = 3'd1,
    G_G_U   = 3'd2,
    G_G_V   = 3'd3,
    G_B_U   = 3'd4,
    G_YC_Y  = 3'd5,
    G_CB    = 3'd6,
    G_CR    = 3'd7
  } gain_sel_t;

  // load enables of the multiplier lane stages
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } mul_en_t;

  // load enables of the mixing and output stages
  typedef struct packed {
    logic s5;
    logic s6;
    logic s7;
  } mix_en_t;

  // matrix and range constants in Q16, rounded
  function automatic logic [KQ_W-1:0] kq_of(input logic [2:0] sel);
    logic [KQ_W-1:0] kq;
    unique case (sel)
      G_RGB_Y: kq = 34'd4294901760;
      G_R_V:   kq = 34'd4895685503;
      G_G_U:   kq = 34'd1694948620;
      G_G_V:   kq = 34'd2493714450;
      G_B_U:   kq = 34'd8727506660;
      G_YC_Y:  kq = 34'd3674210304;
      G_CB:    kq = 34'd4309698535;
      G_CR:    kq = 34'd3055484452;
      default: kq = '0;
    endcase
    return kq;
  endfunction

endpackage

// ===== sv/yuv_to_rgb_ycbcr_pixel_converter_unit.sv =====
// ----------------------------------------------------------------------------
// yuv_to_rgb_ycbcr_pixel_converter_unit
// Y'UV sample triple to RGB48, Y'CbCr 4:4:4 or gray16 pixel, one per clock when not stalled.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while in_tready is high, through its stages: one
// for the level subtract and magnitudes, three in the scaling multiplier
// lanes, two for the luma clamp and matrix sums, and the output register.
// The pipeline only stalls where out_tready is low and no bubble is left.
// After reset, and after each write to a mapped configuration register, the
// eight channel gains are recomputed by one shared restoring divider at one
// quotient bit per cycle; in_tready stays low until all eight are done, while
// configuration writes are still taken.
module yuv_to_rgb_ycbcr_pixel_converter_unit
  import yuvrgb_pkg::*;
#(
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // luma_in[15:0], blue_diff_in[32:16], red_diff_in[49:33]
  input  logic        in_tuser,   // is_padding
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // comp_first[15:0], comp_second[31:16], comp_third[47:32]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int P  = GAIN_FRAC_BITS - 16;
  localparam int GW = KQ_W + P;
  localparam int SW = GW + 1;

  logic [1:0]  fmt_r;
  logic [15:0] black_r;
  logic [15:0] white_r;
  logic        cfg_hit;

  logic [GW-1:0] gain [KQ_NUM];
  logic          gains_ok;

  logic [15:0] luma_in;
  logic [16:0] blue_diff_in;
  logic [16:0] red_diff_in;
  logic        in_xfer;

  logic [7:1] v_r;
  logic [8:1] rdy;

  logic [16:0] my1_r, mu1_r, mv1_r;
  logic        ny1_r, nu1_r, nv1_r;
  logic [4:1]  pad_r;

  mul_en_t mul_en;
  mix_en_t mix_en;
  logic    is_rgb;

  logic signed [SW-1:0] sc_y, sc_v, sc_u, sc_gu, sc_gv;
  logic [15:0] comp_first, comp_second, comp_third;

  // configuration
  assign cfg_ready = 1'b1;

  always_comb begin
    unique case (cfg_index)
      CFG_OUTPUT_FORMAT, CFG_BLACK_LEVEL, CFG_WHITE_LEVEL: cfg_hit = cfg_valid;
      default:                                             cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r   <= FMT_RGB48;
      black_r <= '0;
      white_r <= 16'hFFFF;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_OUTPUT_FORMAT: fmt_r   <= cfg_data[1:0];
        CFG_BLACK_LEVEL:   black_r <= cfg_data;
        CFG_WHITE_LEVEL:   white_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  yuvrgb_gain_calc #(
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_gain_calc (
    .clk        (clk),
    .rst_n      (rst_n),
    .restart    (cfg_hit),
    .black_level(black_r),
    .white_level(white_r),
    .gain       (gain),
    .gains_ok   (gains_ok)
  );

  // pipeline flow: a stage loads when it is empty or its content moves on
  always_comb begin
    rdy[8] = out_tready;
    for (int k = 7; k >= 1; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign in_tready = rdy[1] && gains_ok;
  assign in_xfer   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[1]) begin
        v_r[1] <= in_xfer;
      end
      for (int k = 2; k <= 7; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // stage 1: level subtract and sign-magnitude split
  assign luma_in      = in_tdata[15:0];
  assign blue_diff_in = in_tdata[32:16];
  assign red_diff_in  = in_tdata[49:33];

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      ny1_r    <= (luma_in < black_r);
      my1_r    <= (luma_in < black_r) ? 17'(black_r - luma_in) : 17'(luma_in - black_r);
      nu1_r    <= blue_diff_in[16];
      mu1_r    <= blue_diff_in[16] ? -blue_diff_in : blue_diff_in;
      nv1_r    <= red_diff_in[16];
      mv1_r    <= red_diff_in[16] ? -red_diff_in : red_diff_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      pad_r[1] <= in_tuser;
    end
    for (int k = 2; k <= 4; k++) begin
      if (rdy[k]) begin
        pad_r[k] <= pad_r[k-1];
      end
    end
  end

  assign mul_en = '{s2: rdy[2], s3: rdy[3], s4: rdy[4]};
  assign mix_en = '{s5: rdy[5], s6: rdy[6], s7: rdy[7]};
  assign is_rgb = (fmt_r == FMT_RGB48);

  // the rgb and ycbcr paths share the luma and two chroma lanes
  yuvrgb_scale_mul #(.GW(GW)) u_mul_y (
    .clk(clk), .en(mul_en), .mag(my1_r), .neg(ny1_r),
    .gain(is_rgb ? gain[G_RGB_Y] : gain[G_YC_Y]), .scaled(sc_y)
  );

  yuvrgb_scale_mul #(.GW(GW)) u_mul_v (
    .clk(clk), .en(mul_en), .mag(mv1_r), .neg(nv1_r),
    .gain(is_rgb ? gain[G_R_V] : gain[G_CR]), .scaled(sc_v)
  );

  yuvrgb_scale_mul #(.GW(GW)) u_mul_u (
    .clk(clk), .en(mul_en), .mag(mu1_r), .neg(nu1_r),
    .gain(is_rgb ? gain[G_B_U] : gain[G_CB]), .scaled(sc_u)
  );

  yuvrgb_scale_mul #(.GW(GW)) u_mul_gu (
    .clk(clk), .en(mul_en), .mag(mu1_r), .neg(nu1_r),
    .gain(gain[G_G_U]), .scaled(sc_gu)
  );

  yuvrgb_scale_mul #(.GW(GW)) u_mul_gv (
    .clk(clk), .en(mul_en), .mag(mv1_r), .neg(nv1_r),
    .gain(gain[G_G_V]), .scaled(sc_gv)
  );

  yuvrgb_mix #(
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_mix (
    .clk        (clk),
    .en         (mix_en),
    .fmt        (fmt_r),
    .pad        (pad_r[4]),
    .lane_y     (sc_y),
    .lane_v     (sc_v),
    .lane_u     (sc_u),
    .lane_gu    (sc_gu),
    .lane_gv    (sc_gv),
    .comp_first (comp_first),
    .comp_second(comp_second),
    .comp_third (comp_third)
  );

  assign out_tvalid = v_r[7];
  assign out_tdata  = {comp_third, comp_second, comp_first};

endmodule

// ===== sv/yuvrgb_gain_calc.sv =====
// ----------------------------------------------------------------------------
// yuvrgb_gain_calc
// Works out the eight channel gains round(Kq * 2^P / range) with one shared
// restoring divider, one quotient bit per cycle, one gain after another.
// ----------------------------------------------------------------------------
module yuvrgb_gain_calc
  import yuvrgb_pkg::*;
#(
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
  localparam int P  = GAIN_FRAC_BITS - 16,
  localparam int GW = KQ_W + P
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          restart,
  input  logic [15:0]   black_level,
  input  logic [15:0]   white_level,
  output logic [GW-1:0] gain [KQ_NUM],
  output logic          gains_ok
);

  localparam int DW = KQ_W + 1 + P;
  localparam int CW = $clog2(DW);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV
  } state_t;

  state_t        state_r;
  logic [2:0]    idx_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] dvd_r;
  logic [15:0]   rem_r;
  logic [GW-1:0] gain_r [KQ_NUM];

  logic [15:0]   range;
  logic [16:0]   trial;
  logic [16:0]   trial_sub;
  logic          ge;
  logic [15:0]   rem_nxt;
  logic [DW-1:0] dvd_nxt;
  logic [DW-1:0] dvd_init;

  // an empty level range counts as a range of one
  assign range = (white_level > black_level) ? (white_level - black_level) : 16'd1;

  assign dvd_init  = (DW'(kq_of(idx_r)) << P) + DW'(range >> 1);
  assign trial     = {rem_r, dvd_r[DW-1]};
  assign trial_sub = trial - {1'b0, range};
  assign ge        = (trial >= {1'b0, range});
  assign rem_nxt   = ge ? trial_sub[15:0] : trial[15:0];
  // quotient bits shift in where the dividend bits leave
  assign dvd_nxt   = {dvd_r[DW-2:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      idx_r   <= '0;
      cnt_r   <= '0;
    end else if (restart) begin
      state_r <= ST_LOAD;
      idx_r   <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
        end
        ST_LOAD: begin
          dvd_r   <= dvd_init;
          rem_r   <= '0;
          cnt_r   <= CW'(DW - 1);
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          dvd_r <= dvd_nxt;
          rem_r <= rem_nxt;
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            gain_r[idx_r] <= dvd_nxt[GW-1:0];
            if (idx_r == 3'(KQ_NUM - 1)) begin
              state_r <= ST_IDLE;
            end else begin
              idx_r   <= idx_r + 1'b1;
              state_r <= ST_LOAD;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign gain     = gain_r;
  assign gains_ok = (state_r == ST_IDLE);

endmodule

// ===== sv/yuvrgb_scale_mul.sv =====
// ----------------------------------------------------------------------------
// yuvrgb_scale_mul
// One scaling lane: sign * floor(|s| * gain / 2^16) over three stages
// (partial products, product sum, sign).
// ----------------------------------------------------------------------------
module yuvrgb_scale_mul
  import yuvrgb_pkg::*;
#(
  parameter int GW = KQ_W + GAIN_FRAC_BITS_DEF - 16
) (
  input  logic                 clk,
  input  mul_en_t              en,
  input  logic [16:0]          mag,
  input  logic                 neg,
  input  logic [GW-1:0]        gain,
  output logic signed [GW:0]   scaled
);

  logic [32:0]          lo_r;
  logic [GW:0]          hi_r;
  logic                 neg2_r;
  logic [GW-1:0]        sum_r;
  logic                 neg3_r;
  logic signed [GW:0]   res_r;
  logic [GW:0]          sum_nxt;

  // split the gain so each product stays narrow
  always_ff @(posedge clk) begin
    if (en.s2) begin
      lo_r   <= 33'(mag) * 33'(gain[15:0]);
      hi_r   <= (GW+1)'(mag) * (GW+1)'(gain[GW-1:16]);
      neg2_r <= neg;
    end
  end

  assign sum_nxt = hi_r + (GW+1)'(lo_r >> 16);

  always_ff @(posedge clk) begin
    if (en.s3) begin
      sum_r  <= sum_nxt[GW-1:0];
      neg3_r <= neg2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      res_r <= neg3_r ? -$signed({1'b0, sum_r}) : $signed({1'b0, sum_r});
    end
  end

  assign scaled = res_r;

endmodule

// ===== sv/yuvrgb_mix.sv =====
// ----------------------------------------------------------------------------
// yuvrgb_mix
// Luma clamp, matrix sums and offsets, then the final clamp to 16 bits and
// the padding and gray overrides; the last stage is the output register.
// ----------------------------------------------------------------------------
module yuvrgb_mix
  import yuvrgb_pkg::*;
#(
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
  localparam int P  = GAIN_FRAC_BITS - 16,
  localparam int SW = KQ_W + P + 1
) (
  input  logic                 clk,
  input  mix_en_t              en,
  input  logic [1:0]           fmt,
  input  logic                 pad,
  input  logic signed [SW-1:0] lane_y,
  input  logic signed [SW-1:0] lane_v,
  input  logic signed [SW-1:0] lane_u,
  input  logic signed [SW-1:0] lane_gu,
  input  logic signed [SW-1:0] lane_gv,
  output logic [15:0]          comp_first,
  output logic [15:0]          comp_second,
  output logic [15:0]          comp_third
);

  localparam int AW = SW + 2;
  localparam logic signed [SW-1:0] RY_MAX = signed'(SW'(65535) << P);
  localparam logic signed [AW-1:0] OFS_Y  = signed'(AW'(4096) << P);
  localparam logic signed [AW-1:0] OFS_C  = signed'(AW'(32768) << P);

  logic                 is_rgb;
  logic                 is_ycc;

  logic signed [SW-1:0] ry5_r;
  logic signed [AW-1:0] tg5_r;
  logic signed [SW-1:0] v5_r;
  logic signed [SW-1:0] u5_r;
  logic                 pad5_r;
  logic signed [SW-1:0] ry_nxt;

  logic signed [AW-1:0] f6_r;
  logic signed [AW-1:0] s6_r;
  logic signed [AW-1:0] t6_r;
  logic                 pad6_r;

  logic [15:0]          first_r;
  logic [15:0]          second_r;
  logic [15:0]          third_r;
  logic [15:0]          lo;
  logic [15:0]          hi;
  logic [15:0]          f_cl;
  logic [15:0]          s_cl;
  logic [15:0]          t_cl;

  assign is_rgb = (fmt == FMT_RGB48);
  assign is_ycc = (fmt == FMT_YCC444);

  function automatic logic [15:0] clamp16(input logic signed [AW-1:0] v,
                                          input logic [15:0] lo_v,
                                          input logic [15:0] hi_v);
    logic signed [AW-1:0] lo_x;
    logic signed [AW-1:0] hi_x;
    logic [15:0]          r;
    lo_x = signed'(AW'(lo_v) << P);
    hi_x = signed'(AW'(hi_v) << P);
    if (v < lo_x) begin
      r = lo_v;
    end else if (v > hi_x) begin
      r = hi_v;
    end else begin
      r = v[P +: 16];
    end
    return r;
  endfunction

  // rgb luma is clamped before the matrix; other formats pass it unchanged
  always_comb begin
    ry_nxt = lane_y;
    if (is_rgb) begin
      if (lane_y < 0) begin
        ry_nxt = '0;
      end else if (lane_y > RY_MAX) begin
        ry_nxt = RY_MAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.s5) begin
      ry5_r  <= ry_nxt;
      tg5_r  <= AW'(lane_gu) + AW'(lane_gv);
      v5_r   <= lane_v;
      u5_r   <= lane_u;
      pad5_r <= pad;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s6) begin
      if (is_rgb) begin
        f6_r <= AW'(ry5_r) + AW'(v5_r);
        s6_r <= AW'(ry5_r) - tg5_r;
        t6_r <= AW'(ry5_r) + AW'(u5_r);
      end else begin
        f6_r <= AW'(ry5_r) + OFS_Y;
        s6_r <= AW'(u5_r) + OFS_C;
        t6_r <= AW'(v5_r) + OFS_C;
      end
      pad6_r <= pad5_r;
    end
  end

  assign lo   = is_rgb ? 16'd0 : 16'd256;
  assign hi   = is_rgb ? 16'd65535 : 16'd65216;
  assign f_cl = clamp16(f6_r, lo, hi);
  assign s_cl = clamp16(s6_r, lo, hi);
  assign t_cl = clamp16(t6_r, lo, hi);

  always_ff @(posedge clk) begin
    if (en.s7) begin
      if (is_rgb) begin
        first_r  <= pad6_r ? 16'd0 : f_cl;
        second_r <= pad6_r ? 16'd0 : s_cl;
        third_r  <= pad6_r ? 16'd0 : t_cl;
      end else if (is_ycc) begin
        first_r  <= pad6_r ? 16'd4096 : f_cl;
        second_r <= pad6_r ? 16'd32768 : s_cl;
        third_r  <= pad6_r ? 16'd32768 : t_cl;
      end else begin
        first_r  <= pad6_r ? 16'd4096 : f_cl;
        second_r <= 16'd0;
        third_r  <= 16'd0;
      end
    end
  end

  assign comp_first  = first_r;
  assign comp_second = second_r;
  assign comp_third  = third_r;

endmodule

// ===== verif/tb_yuv_to_rgb_ycbcr_pixel_converter_unit.sv =====
// ----------------------------------------------------------------------------
// tb_yuv_to_rgb_ycbcr_pixel_converter_unit
// Streams Y'UV sample triples through the converter under every output format
// and a spread of black and white levels, predicts each pixel with a
// fixed-point model kept inside the bench, and compares all three components
// of every output transfer. Both stream sides idle at random, and one long
// output stall fills the pipeline so that the input side has to back off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_yuv_to_rgb_ycbcr_pixel_converter_unit;
  import yuvrgb_pkg::*;

  localparam int     FRAC        = GAIN_FRAC_BITS_DEF - 16;
  localparam longint ONE         = longint'(1) << FRAC;
  localparam int     GAP_MAX     = 13;
  localparam int     HOLD_CYCLES = 400;
  localparam int     CYCLE_LIMIT = 500000;
  localparam int     DRAIN_CYCLES = 32;
  localparam int     PHASES      = 12;
  localparam int     PHASE_ITEMS = 120;
  localparam int     MAX_REPORTS = 10;

  localparam logic [1:0] FMT_UNUSED = 2'd3;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  // matrix and range constants in Q16
  localparam longint unsigned K_RGB_Y = 64'd4294901760;
  localparam longint unsigned K_R_V   = 64'd4895685503;
  localparam longint unsigned K_G_U   = 64'd1694948620;
  localparam longint unsigned K_G_V   = 64'd2493714450;
  localparam longint unsigned K_B_U   = 64'd8727506660;
  localparam longint unsigned K_YC_Y  = 64'd3674210304;
  localparam longint unsigned K_CB    = 64'd4309698535;
  localparam longint unsigned K_CR    = 64'd3055484452;

  typedef struct {
    logic [15:0]        luma;
    logic signed [16:0] u_diff;
    logic signed [16:0] v_diff;
    logic               pad;
  } yuv_sample_t;

  typedef struct packed {
    logic [15:0] third;
    logic [15:0] second;
    logic [15:0] first;
  } pixel_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;   // luma_in[15:0], blue_diff_in[32:16], red_diff_in[49:33]
  logic        in_tuser;   // is_padding
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // comp_first[15:0], comp_second[31:16], comp_third[47:32]
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  // converter settings as the bench sees them, and the gains derived from them
  logic [1:0]  fmt_r;
  logic [15:0] black_r;
  logic [15:0] white_r;
  longint unsigned g_rgb_y, g_r_v, g_g_u, g_g_v, g_b_u, g_yc_y, g_cb, g_cr;

  pixel_t expected_pixels[$];
  pixel_t got_px;
  pixel_t want_px;
  int     err_cnt = 0;
  int     cycle_cnt = 0;
  bit     send_gaps_on = 1'b0;
  bit     recv_gaps_on = 1'b0;
  bit     hold_req = 1'b0;

  yuv_to_rgb_ycbcr_pixel_converter_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint unsigned level_gain(longint unsigned kq, longint unsigned span);
    return ((kq << FRAC) + span / 2) / span;
  endfunction

  function automatic void update_gains();
    longint unsigned span;
    span = (white_r > black_r) ? longint'(white_r) - longint'(black_r) : 1;
    g_rgb_y = level_gain(K_RGB_Y, span);
    g_r_v   = level_gain(K_R_V, span);
    g_g_u   = level_gain(K_G_U, span);
    g_g_v   = level_gain(K_G_V, span);
    g_b_u   = level_gain(K_B_U, span);
    g_yc_y  = level_gain(K_YC_Y, span);
    g_cb    = level_gain(K_CB, span);
    g_cr    = level_gain(K_CR, span);
  endfunction

  // signed sample times gain, truncated toward zero to FRAC fraction bits
  function automatic longint scale_fix(longint s, longint unsigned g);
    longint unsigned mag;
    longint unsigned prod;
    mag  = (s < 0) ? -s : s;
    prod = mag * (g >> 16) + ((mag * (g & 64'hFFFF)) >> 16);
    return (s < 0) ? -longint'(prod) : longint'(prod);
  endfunction

  function automatic logic [15:0] clamp_px(longint val, longint lo, longint hi);
    if (val < lo * ONE) val = lo * ONE;
    if (val > hi * ONE) val = hi * ONE;
    return val[FRAC+15:FRAC];
  endfunction

  function automatic pixel_t predict_pixel(yuv_sample_t s);
    pixel_t p;
    longint diff;
    longint u;
    longint v;
    longint ry;
    diff = longint'(s.luma) - longint'(black_r);
    u    = s.u_diff;
    v    = s.v_diff;
    case (fmt_r)
      FMT_RGB48: begin
        if (s.pad) begin
          p = '0;
        end else begin
          ry = scale_fix(diff, g_rgb_y);
          if (ry < 0) ry = 0;
          if (ry > 65535 * ONE) ry = 65535 * ONE;
          p.first  = clamp_px(ry + scale_fix(v, g_r_v), 0, 65535);
          p.second = clamp_px(ry - scale_fix(u, g_g_u) - scale_fix(v, g_g_v), 0, 65535);
          p.third  = clamp_px(ry + scale_fix(u, g_b_u), 0, 65535);
        end
      end
      FMT_YCC444: begin
        if (s.pad) begin
          p.first  = 16'd4096;
          p.second = 16'd32768;
          p.third  = 16'd32768;
        end else begin
          p.first  = clamp_px(scale_fix(diff, g_yc_y) + 4096 * ONE, 256, 65216);
          p.second = clamp_px(scale_fix(u, g_cb) + 32768 * ONE, 256, 65216);
          p.third  = clamp_px(scale_fix(v, g_cr) + 32768 * ONE, 256, 65216);
        end
      end
      default: begin
        // gray, and the unused format code
        p.first  = s.pad ? 16'd4096 : clamp_px(scale_fix(diff, g_yc_y) + 4096 * ONE, 256, 65216);
        p.second = '0;
        p.third  = '0;
      end
    endcase
    return p;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic yuv_sample_t mk_sample(int luma, int u, int v, bit pad);
    yuv_sample_t s;
    s.luma   = luma[15:0];
    s.u_diff = u[16:0];
    s.v_diff = v[16:0];
    s.pad    = pad;
    return s;
  endfunction

  function automatic int rand_chroma();
    case ($urandom_range(0, 9))
      0:       return -65536;
      1:       return 65535;
      2:       return $urandom_range(0, 600) - 300;
      default: return $urandom_range(0, 17'h1FFFF);
    endcase
  endfunction

  function automatic yuv_sample_t rand_sample();
    int luma;
    case ($urandom_range(0, 7))
      0:       luma = $urandom_range(0, 1) ? 65535 : 0;
      1:       luma = int'(black_r) + int'($urandom_range(0, 200)) - 100;
      2:       luma = int'(white_r) + int'($urandom_range(0, 200)) - 100;
      default: luma = $urandom_range(0, 65535);
    endcase
    if (luma < 0) luma = 0;
    if (luma > 65535) luma = 65535;
    return mk_sample(luma, rand_chroma(), rand_chroma(), $urandom_range(0, 7) == 0);
  endfunction

  // one input transfer; entered and left at a falling edge
  task automatic send_pixel(yuv_sample_t s);
    int gap;
    gap = send_gaps_on ? $urandom_range(0, GAP_MAX) : 0;
    repeat (gap) @(negedge clk);
    in_tdata  = {6'b0, s.v_diff, s.u_diff, s.luma};
    in_tuser  = s.pad;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    expected_pixels.push_back(predict_pixel(s));
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  // register write, only once every pending pixel has come out
  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    while (expected_pixels.size() != 0) @(negedge clk);
    cfg_index = idx;
    cfg_data  = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_OUTPUT_FORMAT: fmt_r   = val[1:0];
      CFG_BLACK_LEVEL:   black_r = val;
      CFG_WHITE_LEVEL:   white_r = val;
      default: ;
    endcase
    update_gains();
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic rand_settings();
    int b;
    int w;
    case ($urandom_range(0, 9))
      0, 1, 2: write_reg(CFG_OUTPUT_FORMAT, FMT_RGB48);
      3, 4, 5: write_reg(CFG_OUTPUT_FORMAT, FMT_YCC444);
      6, 7, 8: write_reg(CFG_OUTPUT_FORMAT, FMT_GRAY16);
      default: write_reg(CFG_OUTPUT_FORMAT, FMT_UNUSED);
    endcase
    case ($urandom_range(0, 5))
      0: begin b = $urandom_range(0, 4096); w = $urandom_range(60000, 65535); end
      1: begin b = $urandom_range(0, 65535); w = $urandom_range(0, 65535); end
      2: begin b = 0; w = 65535; end
      3: begin b = $urandom_range(1000, 40000); w = b + $urandom_range(1, 64); end
      4: begin w = $urandom_range(0, 30000); b = w + $urandom_range(0, 30000); end
      default: begin b = $urandom_range(0, 65535); w = b; end
    endcase
    write_reg(CFG_BLACK_LEVEL, b[15:0]);
    write_reg(CFG_WHITE_LEVEL, w[15:0]);
  endtask

  // ---------------------------------------------------------------- tests

  // reset levels: full range, RGB48
  task automatic test_rgb_extremes();
    send_pixel(mk_sample(0, 0, 0, 1'b0));
    send_pixel(mk_sample(65535, 0, 0, 1'b0));
    send_pixel(mk_sample(32768, 65535, 65535, 1'b0));
    send_pixel(mk_sample(32768, -65536, -65536, 1'b0));
    send_pixel(mk_sample(65535, 65535, -65536, 1'b0));
    send_pixel(mk_sample(0, -65536, 65535, 1'b0));
    send_pixel(mk_sample(12345, 17'h0AAAA, 17'h15555, 1'b1));
    send_pixel(mk_sample(40000, 17'h15555, 17'h0AAAA, 1'b0));
  endtask

  task automatic test_ycc_extremes();
    write_reg(CFG_OUTPUT_FORMAT, FMT_YCC444);
    send_pixel(mk_sample(0, -65536, -65536, 1'b0));
    send_pixel(mk_sample(65535, 65535, 65535, 1'b0));
    send_pixel(mk_sample(32768, 0, 0, 1'b0));
    send_pixel(mk_sample(65535, 65535, 65535, 1'b1));
    send_pixel(mk_sample(4096, 100, -100, 1'b0));
  endtask

  task automatic test_gray_formats();
    write_reg(CFG_OUTPUT_FORMAT, FMT_GRAY16);
    send_pixel(mk_sample(0, 65535, -65536, 1'b0));
    send_pixel(mk_sample(65535, -65536, 65535, 1'b0));
    send_pixel(mk_sample(20000, 5, 5, 1'b1));
    // unused format code falls back to gray
    write_reg(CFG_OUTPUT_FORMAT, FMT_UNUSED);
    send_pixel(mk_sample(30000, 1234, -4321, 1'b0));
    send_pixel(mk_sample(0, 0, 0, 1'b1));
  endtask

  task automatic test_level_ranges();
    // white below black: range of one
    write_reg(CFG_OUTPUT_FORMAT, FMT_RGB48);
    write_reg(CFG_BLACK_LEVEL, 16'hFFFF);
    write_reg(CFG_WHITE_LEVEL, 16'h0000);
    send_pixel(mk_sample(65535, 1, -1, 1'b0));
    send_pixel(mk_sample(0, 0, 0, 1'b0));
    // white equal to black, luma either side
    write_reg(CFG_OUTPUT_FORMAT, FMT_YCC444);
    write_reg(CFG_BLACK_LEVEL, 16'd20000);
    write_reg(CFG_WHITE_LEVEL, 16'd20000);
    send_pixel(mk_sample(19999, 1, -1, 1'b0));
    send_pixel(mk_sample(20001, -1, 1, 1'b0));
    // a write to an unmapped index changes nothing
    write_reg(CFG_UNUSED, 16'hFFFF);
    send_pixel(mk_sample(20000, 3, 3, 1'b0));
    // luma below black gives a negative difference
    write_reg(CFG_OUTPUT_FORMAT, FMT_GRAY16);
    write_reg(CFG_BLACK_LEVEL, 16'd1000);
    write_reg(CFG_WHITE_LEVEL, 16'd60000);
    send_pixel(mk_sample(0, 0, 0, 1'b0));
    write_reg(CFG_OUTPUT_FORMAT, FMT_RGB48);
    send_pixel(mk_sample(500, 300, 300, 1'b0));
  endtask

  task automatic test_random_sweep();
    for (int ph = 0; ph < PHASES; ph++) begin
      rand_settings();
      // first phase runs with no idling on either side
      send_gaps_on = (ph != 0) && ($urandom_range(0, 3) != 0);
      recv_gaps_on = (ph != 0) && ($urandom_range(0, 3) != 0);
      repeat (PHASE_ITEMS) send_pixel(rand_sample());
    end
  endtask

  // long output stall while input keeps coming: pipeline fills, in_tready drops
  task automatic test_backpressure();
    rand_settings();
    send_gaps_on = 1'b0;
    recv_gaps_on = 1'b1;
    hold_req = 1'b1;
    repeat (48) send_pixel(rand_sample());
  endtask

  // ---------------------------------------------------------------- receiver

  initial begin
    int stall;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      stall = recv_gaps_on ? $urandom_range(0, GAP_MAX) : 0;
      if (stall != 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready) && !hold_req);
    end
  end

  // ---------------------------------------------------------------- checker

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_yuv_to_rgb_ycbcr_pixel_converter_unit failed");
      $finish;
    end else if (rst_n && out_tvalid && out_tready) begin
      got_px = out_tdata;
      if (expected_pixels.size() == 0) begin
        if (err_cnt < MAX_REPORTS)
          $display("unexpected pixel transfer: %h %h %h",
                   got_px.first, got_px.second, got_px.third);
        err_cnt++;
      end else begin
        want_px = expected_pixels.pop_front();
        if (got_px.first !== want_px.first || got_px.second !== want_px.second ||
            got_px.third !== want_px.third) begin
          if (err_cnt < MAX_REPORTS)
            $display("pixel mismatch: expected %h %h %h, got %h %h %h",
                     want_px.first, want_px.second, want_px.third,
                     got_px.first, got_px.second, got_px.third);
          err_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- main

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_OUTPUT_FORMAT;
    cfg_data  = '0;
    fmt_r     = FMT_RGB48;
    black_r   = 16'h0000;
    white_r   = 16'hFFFF;
    update_gains();
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    test_rgb_extremes();
    test_ycc_extremes();
    test_gray_formats();
    test_level_ranges();
    test_random_sweep();
    test_backpressure();

    while (expected_pixels.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (err_cnt == 0) begin
      $display("tb_yuv_to_rgb_ycbcr_pixel_converter_unit passed");
    end else begin
      $display("tb_yuv_to_rgb_ycbcr_pixel_converter_unit failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/yuvrgb_pkg.sv
sv/yuvrgb_gain_calc.sv
sv/yuvrgb_scale_mul.sv
sv/yuvrgb_mix.sv
sv/yuv_to_rgb_ycbcr_pixel_converter_unit.sv
verif/tb_yuv_to_rgb_ycbcr_pixel_converter_unit.sv
